// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Invariant checked at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`endif

// ===== rtl/frtpf_pkg.sv =====
package frtpf_pkg;

   localparam int RULE_ENTRIES_DEF  = 256;
   localparam int WATCH_ENTRIES_DEF = 16;

   localparam logic [9:0] TIMEOUT_RESET = 10'd30;

   localparam logic [2:0] OP_PACKET     = 3'd0;
   localparam logic [2:0] OP_ADD        = 3'd1;
   localparam logic [2:0] OP_REMOVE_TAG = 3'd2;
   localparam logic [2:0] OP_DISABLE    = 3'd3;
   localparam logic [2:0] OP_AGE        = 3'd4;
   localparam logic [2:0] OP_WATCH_ADD  = 3'd5;
   localparam logic [2:0] OP_WATCH_DEL  = 3'd6;
   localparam logic [2:0] OP_RENEW      = 3'd7;

   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_DUP  = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;
   localparam logic [1:0] STS_MISS = 2'd3;

   localparam logic [1:0] PROTO_TCP = 2'd1;
   localparam logic [1:0] PROTO_UDP = 2'd2;

   localparam logic [1:0] MODE_EXACT = 2'd0;
   localparam logic [1:0] MODE_FIRST = 2'd1;
   localparam logic [1:0] MODE_ANY   = 2'd2;
   localparam logic [1:0] MODE_PERM  = 2'd3;

   localparam int FLAG_ENABLED   = 0;
   localparam int FLAG_PERMANENT = 1;
   localparam int FLAG_FIRST     = 2;
   localparam int FLAG_ANY       = 3;

   typedef struct packed {
      logic [3:0]  flags;
      logic        udp;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] tag;
      logic [31:0] last_seen;
   } rule_entry_type;

   typedef struct packed {
      logic        udp;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  mode;
      logic [31:0] tag;
      logic [31:0] limit;
   } rule_key_type;

   typedef struct packed {
      logic any_hit;
      logic exact_hit;
      logic first_hit;
      logic dup;
      logic free;
      logic tag_hit;
      logic stale;
      logic renew;
   } rule_hit_type;

   typedef struct packed {
      logic [15:0] port;
      logic [31:0] ip;
   } watch_entry_type;

endpackage

// ===== rtl/frtpf_ram.sv =====
module frtpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/frtpf_eval.sv =====
module frtpf_eval (
   input  frtpf_pkg::rule_entry_type entry,
   input  frtpf_pkg::rule_key_type   key,
   output frtpf_pkg::rule_hit_type   hit
);
   import frtpf_pkg::*;

   logic        en;
   logic        proto_same;
   logic        addr_same;
   logic        new_any;
   logic        new_first;
   logic        port_same;
   logic [15:0] sport_eff;

   assign en         = entry.flags[FLAG_ENABLED];
   assign proto_same = entry.udp == key.udp;
   assign addr_same  = entry.src_ip == key.src_ip && entry.dst_ip == key.dst_ip &&
                       entry.dport == key.dport;
   assign new_any    = key.mode == MODE_ANY || key.mode == MODE_PERM;
   assign new_first  = key.mode == MODE_FIRST;
   assign sport_eff  = (key.mode == MODE_EXACT) ? key.sport : 16'd0;
   assign port_same  = (entry.flags[FLAG_ANY] && new_any) ||
                       (!new_first && !new_any && entry.sport == sport_eff);

   assign hit.any_hit   = en && proto_same && entry.flags[FLAG_ANY] && addr_same;
   assign hit.exact_hit = en && proto_same && addr_same && entry.sport == key.sport;
   assign hit.first_hit = en && proto_same && entry.flags[FLAG_FIRST] &&
                          entry.sport == 16'd0 && addr_same;
   assign hit.dup       = en && proto_same && addr_same && port_same;
   assign hit.free      = !en;
   assign hit.tag_hit   = en && entry.tag == key.tag;
   // signed compare of the wrapped limit against last-seen
   assign hit.stale     = en && !entry.flags[FLAG_PERMANENT] &&
                          ($signed(key.limit) > $signed(entry.last_seen));
   assign hit.renew     = en && entry.flags[FLAG_FIRST];
endmodule

// ===== rtl/flow_rule_table_packet_filter.sv =====
// Flow rule filter: one operation at a time. After reset a clearing pass
// runs through the rule memory with req_stall high. A packet check of TCP or
// UDP first scans the watch list; if the destination is watched, it then makes
// one pass over the rule memory (one entry a cycle through a single shared
// entry comparator, all three match priorities collected in that pass) and
// stamps the hit entry in the fetch and update states. Add rule, remove by
// tag, age and renew take one rule pass, add rule then its fetch and update
// states; disable by index takes only the fetch and update states; watch edits
// take one watch scan. Result in rsp_*; a new request is taken once the
// previous result is registered.
module flow_rule_table_packet_filter #(
   parameter int RULE_ENTRIES  = frtpf_pkg::RULE_ENTRIES_DEF,
   parameter int WATCH_ENTRIES = frtpf_pkg::WATCH_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_now_seconds,
   input  logic [1:0]  req_protocol,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [1:0]  req_rule_mode,
   input  logic [31:0] req_rule_tag,
   input  logic [7:0]  req_rule_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_slot,
   output logic [8:0]  rsp_affected,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_rule_timeout
);
   import frtpf_pkg::*;
   `include "assert_macros.svh"

   localparam int IW = RULE_ENTRIES > 1 ? $clog2(RULE_ENTRIES) : 1;
   localparam int CW = IW + 1;
   localparam int WW = WATCH_ENTRIES > 1 ? $clog2(WATCH_ENTRIES) : 1;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_WATCH  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FETCH  = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [9:0] timeout_ff;

   logic [2:0]   op_ff, op_in;
   logic [31:0]  now_ff, now_in;
   rule_key_type key_ff, key_in;

   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0] pipe_idx_ff, pipe_idx_in;
   logic [IW-1:0] fetch_idx_ff, fetch_idx_in;
   logic          latch_ff, latch_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic          any_fnd_ff, any_fnd_in;
   logic [IW-1:0] any_idx_ff, any_idx_in;
   logic          exact_fnd_ff, exact_fnd_in;
   logic [IW-1:0] exact_idx_ff, exact_idx_in;
   logic          first_fnd_ff, first_fnd_in;
   logic [IW-1:0] first_idx_ff, first_idx_in;
   logic          dup_ff, dup_in;
   logic          free_fnd_ff, free_fnd_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic [WW-1:0] wcnt_ff, wcnt_in;
   logic          wfnd_ff, wfnd_in;
   logic [WW-1:0] widx_ff, widx_in;
   logic          wfree_ff, wfree_in;
   logic [WW-1:0] wfree_idx_ff, wfree_idx_in;
   logic            watch_valid_ff [WATCH_ENTRIES];
   logic            watch_valid_in [WATCH_ENTRIES];
   watch_entry_type watch_entry_ff [WATCH_ENTRIES];
   watch_entry_type watch_entry_in [WATCH_ENTRIES];
   logic            wmatch;

   logic       res_verdict_ff, res_verdict_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [7:0] res_slot_ff, res_slot_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_verdict_ff, rsp_verdict_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_slot_ff, rsp_slot_in;
   logic [8:0] rsp_affected_ff, rsp_affected_in;
   logic [9:0] cnt_wide;

   logic           ram_wr_en;
   logic [IW-1:0]  ram_wr_addr;
   rule_entry_type ram_wr_data;
   logic [IW-1:0]  ram_rd_addr;
   rule_entry_type ram_rd_data;
   rule_hit_type   hit;
   logic           req_xfer;
   logic           scan_issue;
   logic           scan_last;

   frtpf_ram #(
      .WIDTH($bits(rule_entry_type)),
      .DEPTH(RULE_ENTRIES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   frtpf_eval u_eval (
      .entry (ram_rd_data),
      .key   (key_ff),
      .hit   (hit)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verdict  = rsp_verdict_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_affected = rsp_affected_ff;

   assign scan_issue = scan_cnt_ff < CW'(RULE_ENTRIES);
   assign scan_last  = pipe_vld_ff && pipe_idx_ff == IW'(RULE_ENTRIES - 1);
   assign wmatch     = watch_valid_ff[wcnt_ff] &&
                       watch_entry_ff[wcnt_ff].ip == key_ff.dst_ip &&
                       watch_entry_ff[wcnt_ff].port == key_ff.dport;
   assign cnt_wide   = 10'(cnt_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      now_in         = now_ff;
      key_in         = key_ff;
      scan_cnt_in    = scan_cnt_ff;
      pipe_vld_in    = 1'b0;
      pipe_idx_in    = pipe_idx_ff;
      fetch_idx_in   = fetch_idx_ff;
      latch_in       = latch_ff;
      cnt_in         = cnt_ff;
      any_fnd_in     = any_fnd_ff;
      any_idx_in     = any_idx_ff;
      exact_fnd_in   = exact_fnd_ff;
      exact_idx_in   = exact_idx_ff;
      first_fnd_in   = first_fnd_ff;
      first_idx_in   = first_idx_ff;
      dup_in         = dup_ff;
      free_fnd_in    = free_fnd_ff;
      free_idx_in    = free_idx_ff;
      wcnt_in        = wcnt_ff;
      wfnd_in        = wfnd_ff;
      widx_in        = widx_ff;
      wfree_in       = wfree_ff;
      wfree_idx_in   = wfree_idx_ff;
      watch_valid_in = watch_valid_ff;
      watch_entry_in = watch_entry_ff;
      res_verdict_in = res_verdict_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_affected_in = rsp_affected_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pipe_idx_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_addr    = fetch_idx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_cnt_ff[IW-1:0];
            ram_wr_data = '0;
            scan_cnt_in = scan_cnt_ff + CW'(1);
            if (scan_cnt_ff[IW-1:0] == IW'(RULE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in           = req_opcode;
               now_in          = req_now_seconds;
               key_in.udp      = req_protocol == PROTO_UDP;
               key_in.src_ip   = req_src_ip;
               key_in.dst_ip   = req_dst_ip;
               key_in.sport    = req_sport;
               key_in.dport    = req_dport;
               key_in.mode     = req_rule_mode;
               key_in.tag      = req_rule_tag;
               key_in.limit    = req_now_seconds - 32'(timeout_ff);
               scan_cnt_in     = '0;
               cnt_in          = '0;
               wcnt_in         = '0;
               any_fnd_in      = 1'b0;
               exact_fnd_in    = 1'b0;
               first_fnd_in    = 1'b0;
               dup_in          = 1'b0;
               free_fnd_in     = 1'b0;
               wfnd_in         = 1'b0;
               wfree_in        = 1'b0;
               res_verdict_in  = 1'b0;
               res_status_in   = STS_OK;
               res_slot_in     = 8'd0;
               unique case (req_opcode) inside
                  OP_PACKET: begin
                     if (req_protocol == PROTO_TCP || req_protocol == PROTO_UDP) begin
                        state_in = ST_WATCH;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_ADD: begin
                     if (req_protocol == PROTO_TCP || req_protocol == PROTO_UDP) begin
                        state_in = ST_SCAN;
                     end else begin
                        res_status_in = STS_MISS;
                        state_in      = ST_DONE;
                     end
                  end
                  OP_DISABLE: begin
                     if (10'(req_rule_index) < 10'(RULE_ENTRIES)) begin
                        fetch_idx_in = IW'(req_rule_index);
                        state_in     = ST_FETCH;
                     end else begin
                        res_status_in = STS_MISS;
                        state_in      = ST_DONE;
                     end
                  end
                  OP_WATCH_ADD, OP_WATCH_DEL: state_in = ST_WATCH;
                  default: state_in = ST_SCAN;
               endcase
            end
         end
         ST_WATCH: begin
            wcnt_in = wcnt_ff + WW'(1);
            if (wmatch && !wfnd_ff) begin
               wfnd_in = 1'b1;
               widx_in = wcnt_ff;
            end
            if (!watch_valid_ff[wcnt_ff] && !wfree_ff) begin
               wfree_in     = 1'b1;
               wfree_idx_in = wcnt_ff;
            end
            if (wcnt_ff == WW'(WATCH_ENTRIES - 1)) begin
               state_in = ST_DONE;
               case (op_ff)
                  OP_PACKET: begin
                     if (wfnd_in) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_WATCH_ADD: begin
                     if (wfnd_in) begin
                        res_status_in = STS_DUP;
                     end else if (!wfree_in) begin
                        res_status_in = STS_FULL;
                     end else begin
                        watch_valid_in[wfree_idx_in]      = 1'b1;
                        watch_entry_in[wfree_idx_in].ip   = key_ff.dst_ip;
                        watch_entry_in[wfree_idx_in].port = key_ff.dport;
                        res_slot_in = 8'(wfree_idx_in);
                     end
                  end
                  default: begin
                     if (wfnd_in) begin
                        watch_valid_in[widx_in] = 1'b0;
                        res_slot_in = 8'(widx_in);
                     end else begin
                        res_status_in = STS_MISS;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ram_rd_addr = scan_cnt_ff[IW-1:0];
            pipe_vld_in = scan_issue;
            pipe_idx_in = scan_cnt_ff[IW-1:0];
            if (scan_issue) begin
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end
            if (pipe_vld_ff) begin
               case (op_ff)
                  OP_PACKET: begin
                     if (hit.any_hit && !any_fnd_ff) begin
                        any_fnd_in = 1'b1;
                        any_idx_in = pipe_idx_ff;
                     end
                     if (hit.exact_hit && !exact_fnd_ff) begin
                        exact_fnd_in = 1'b1;
                        exact_idx_in = pipe_idx_ff;
                     end
                     if (hit.first_hit && !first_fnd_ff) begin
                        first_fnd_in = 1'b1;
                        first_idx_in = pipe_idx_ff;
                     end
                  end
                  OP_ADD: begin
                     if (hit.dup) begin
                        dup_in = 1'b1;
                     end
                     if (hit.free && !free_fnd_ff) begin
                        free_fnd_in = 1'b1;
                        free_idx_in = pipe_idx_ff;
                     end
                  end
                  OP_REMOVE_TAG: begin
                     if (hit.tag_hit) begin
                        ram_wr_en = 1'b1;
                        ram_wr_data.flags[FLAG_ENABLED] = 1'b0;
                        cnt_in = cnt_ff + CW'(1);
                        if (cnt_ff == '0) begin
                           res_slot_in = 8'(pipe_idx_ff);
                        end
                     end
                  end
                  OP_AGE: begin
                     if (hit.stale) begin
                        ram_wr_en = 1'b1;
                        ram_wr_data.flags[FLAG_ENABLED] = 1'b0;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  OP_RENEW: begin
                     if (hit.renew) begin
                        ram_wr_en = 1'b1;
                        ram_wr_data.sport = 16'd0;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            if (scan_last) begin
               state_in = ST_DONE;
               case (op_ff)
                  OP_PACKET: begin
                     // any-port wins over exact, exact over first-port
                     if (any_fnd_in) begin
                        fetch_idx_in = any_idx_in;
                        latch_in     = 1'b0;
                        state_in     = ST_FETCH;
                     end else if (exact_fnd_in) begin
                        fetch_idx_in = exact_idx_in;
                        latch_in     = 1'b0;
                        state_in     = ST_FETCH;
                     end else if (first_fnd_in) begin
                        fetch_idx_in = first_idx_in;
                        latch_in     = 1'b1;
                        state_in     = ST_FETCH;
                     end else begin
                        res_verdict_in = 1'b1;
                        res_status_in  = STS_MISS;
                     end
                  end
                  OP_ADD: begin
                     if (dup_in) begin
                        res_status_in = STS_DUP;
                     end else if (!free_fnd_in) begin
                        res_status_in = STS_FULL;
                     end else begin
                        fetch_idx_in = free_idx_in;
                        state_in     = ST_FETCH;
                     end
                  end
                  OP_REMOVE_TAG: begin
                     if (cnt_in == '0) begin
                        res_status_in = STS_MISS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_addr = fetch_idx_ff;
            state_in    = ST_DONE;
            case (op_ff)
               OP_PACKET: begin
                  ram_wr_en             = 1'b1;
                  ram_wr_data.last_seen = now_ff;
                  if (latch_ff) begin
                     ram_wr_data.sport = key_ff.sport;
                  end
                  res_slot_in = 8'(fetch_idx_ff);
               end
               OP_ADD: begin
                  ram_wr_en                = 1'b1;
                  ram_wr_data.flags        = '0;
                  ram_wr_data.flags[FLAG_ENABLED] = 1'b1;
                  ram_wr_data.flags[FLAG_FIRST]   = key_ff.mode == MODE_FIRST;
                  ram_wr_data.flags[FLAG_ANY]     = key_ff.mode == MODE_ANY ||
                                                    key_ff.mode == MODE_PERM;
                  ram_wr_data.flags[FLAG_PERMANENT] = key_ff.mode == MODE_PERM;
                  ram_wr_data.udp          = key_ff.udp;
                  ram_wr_data.src_ip       = key_ff.src_ip;
                  ram_wr_data.dst_ip       = key_ff.dst_ip;
                  ram_wr_data.sport        = (key_ff.mode == MODE_EXACT) ?
                                             key_ff.sport : 16'd0;
                  ram_wr_data.dport        = key_ff.dport;
                  ram_wr_data.tag          = key_ff.tag;
                  ram_wr_data.last_seen    = now_ff;
                  res_slot_in = 8'(fetch_idx_ff);
               end
               OP_DISABLE: begin
                  if (ram_rd_data.flags[FLAG_ENABLED]) begin
                     ram_wr_en = 1'b1;
                     ram_wr_data.flags[FLAG_ENABLED] = 1'b0;
                     res_slot_in = 8'(fetch_idx_ff);
                     cnt_in      = CW'(1);
                  end else begin
                     res_status_in = STS_MISS;
                  end
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_verdict_in  = res_verdict_ff;
               rsp_status_in   = res_status_ff;
               rsp_slot_in     = res_slot_ff;
               rsp_affected_in = (cnt_wide > 10'd511) ? 9'd511 : cnt_wide[8:0];
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_cnt_ff  <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WATCH_ENTRIES; i++) begin
            watch_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         scan_cnt_ff    <= scan_cnt_in;
         pipe_vld_ff    <= pipe_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         watch_valid_ff <= watch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_rule_timeout;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      now_ff          <= now_in;
      key_ff          <= key_in;
      pipe_idx_ff     <= pipe_idx_in;
      fetch_idx_ff    <= fetch_idx_in;
      latch_ff        <= latch_in;
      cnt_ff          <= cnt_in;
      any_fnd_ff      <= any_fnd_in;
      any_idx_ff      <= any_idx_in;
      exact_fnd_ff    <= exact_fnd_in;
      exact_idx_ff    <= exact_idx_in;
      first_fnd_ff    <= first_fnd_in;
      first_idx_ff    <= first_idx_in;
      dup_ff          <= dup_in;
      free_fnd_ff     <= free_fnd_in;
      free_idx_ff     <= free_idx_in;
      wcnt_ff         <= wcnt_in;
      wfnd_ff         <= wfnd_in;
      widx_ff         <= widx_in;
      wfree_ff        <= wfree_in;
      wfree_idx_ff    <= wfree_idx_in;
      watch_entry_ff  <= watch_entry_in;
      res_verdict_ff  <= res_verdict_in;
      res_status_ff   <= res_status_in;
      res_slot_ff     <= res_slot_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_affected_ff <= rsp_affected_in;
   end

   `ASSERT_IMPLIES(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !ram_wr_en)
   `ASSERT_ALWAYS(a_scan_bound, clock, reset, scan_cnt_ff <= CW'(RULE_ENTRIES))
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
endmodule

// ===== sim/tb_flow_rule_table_packet_filter.sv =====
module tb_flow_rule_table_packet_filter;
   timeunit 1ns;
   timeprecision 1ps;
   import frtpf_pkg::*;

   localparam int NRULE  = RULE_ENTRIES_DEF;
   localparam int NWATCH = WATCH_ENTRIES_DEF;
   localparam int STALL_LIMIT = 6000;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now;
      logic [1:0]  proto;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  mode;
      logic [31:0] tag;
      logic [7:0]  idx;
   } filter_req_type;

   typedef struct packed {
      logic       verdict;
      logic [1:0] status;
      logic [7:0] slot;
      logic [8:0] affected;
   } filter_rsp_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   filter_req_type req = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic           rsp_verdict;
   logic [1:0]     rsp_status;
   logic [7:0]     rsp_slot;
   logic [8:0]     rsp_affected;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [9:0]     csr_rule_timeout = '0;

   flow_rule_table_packet_filter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req.op), .req_now_seconds(req.now), .req_protocol(req.proto),
      .req_src_ip(req.sip), .req_dst_ip(req.dip), .req_sport(req.sport),
      .req_dport(req.dport), .req_rule_mode(req.mode), .req_rule_tag(req.tag),
      .req_rule_index(req.idx),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_verdict(rsp_verdict),
      .rsp_status(rsp_status), .rsp_slot(rsp_slot), .rsp_affected(rsp_affected),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_rule_timeout(csr_rule_timeout)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // filter state mirror
   logic [3:0]  rule_flags [NRULE];
   logic        rule_udp   [NRULE];
   logic [31:0] rule_sip   [NRULE];
   logic [31:0] rule_dip   [NRULE];
   logic [15:0] rule_sport [NRULE];
   logic [15:0] rule_dport [NRULE];
   logic [31:0] rule_tag   [NRULE];
   logic [31:0] rule_seen  [NRULE];
   logic        watch_on   [NWATCH];
   logic [31:0] watch_ip   [NWATCH];
   logic [15:0] watch_port [NWATCH];
   logic [9:0]  timeout_secs = TIMEOUT_RESET;

   filter_rsp_type expected_outcomes[$];
   int          fail_count = 0;
   int          quiet_cycles = 0;
   logic        gaps_enabled = 1'b1;
   logic [31:0] clock_secs = 32'd1000;

   logic [31:0] pool_ip   [4] = '{32'h0A000001, 32'hC0A80102, 32'hFFFFFFFE, 32'h00000000};
   logic [15:0] pool_port [4] = '{16'd80, 16'd443, 16'hFFFF, 16'd0};
   logic [31:0] pool_tag  [4] = '{32'd1, 32'd2, 32'hFFFFFFFF, 32'h80000000};

   function automatic int find_watch(logic [31:0] ip, logic [15:0] port);
      for (int i = 0; i < NWATCH; i++)
         if (watch_on[i] && watch_ip[i] == ip && watch_port[i] == port) return i;
      return -1;
   endfunction

   function automatic filter_rsp_type predict_filter_outcome(filter_req_type r);
      filter_rsp_type o;
      int          hit;
      int          cnt;
      logic        udp;
      logic        dup;
      logic        same_port;
      logic [3:0]  fl;
      logic [15:0] sp;
      logic [31:0] lim;
      o = '0;
      hit = -1;
      cnt = 0;
      udp = (r.proto == PROTO_UDP);
      case (r.op)
         OP_PACKET: begin
            if ((r.proto == PROTO_TCP || r.proto == PROTO_UDP) &&
                find_watch(r.dip, r.dport) >= 0) begin
               for (int i = 0; i < NRULE && hit < 0; i++)
                  if (rule_flags[i][FLAG_ENABLED] && rule_udp[i] == udp &&
                      rule_flags[i][FLAG_ANY] && rule_sip[i] == r.sip &&
                      rule_dip[i] == r.dip && rule_dport[i] == r.dport) hit = i;
               for (int i = 0; i < NRULE && hit < 0; i++)
                  if (rule_flags[i][FLAG_ENABLED] && rule_udp[i] == udp &&
                      rule_sip[i] == r.sip && rule_sport[i] == r.sport &&
                      rule_dip[i] == r.dip && rule_dport[i] == r.dport) hit = i;
               for (int i = 0; i < NRULE && hit < 0; i++)
                  if (rule_flags[i][FLAG_ENABLED] && rule_udp[i] == udp &&
                      rule_flags[i][FLAG_FIRST] && rule_sport[i] == 16'd0 &&
                      rule_sip[i] == r.sip && rule_dip[i] == r.dip &&
                      rule_dport[i] == r.dport) begin
                     rule_sport[i] = r.sport;
                     hit = i;
                  end
               if (hit >= 0) begin
                  rule_seen[hit] = r.now;
                  o.slot = hit[7:0];
               end else begin
                  o.verdict = 1'b1;
                  o.status = STS_MISS;
               end
            end
         end
         OP_ADD: begin
            if (r.proto != PROTO_TCP && r.proto != PROTO_UDP) begin
               o.status = STS_MISS;
            end else begin
               fl = '0;
               if (r.mode == MODE_FIRST) fl[FLAG_FIRST] = 1'b1;
               if (r.mode == MODE_ANY || r.mode == MODE_PERM) fl[FLAG_ANY] = 1'b1;
               if (r.mode == MODE_PERM) fl[FLAG_PERMANENT] = 1'b1;
               sp = (r.mode == MODE_EXACT) ? r.sport : 16'd0;
               dup = 1'b0;
               for (int i = 0; i < NRULE && !dup; i++) begin
                  if (!rule_flags[i][FLAG_ENABLED]) continue;
                  same_port = (rule_flags[i][FLAG_ANY] && fl[FLAG_ANY]) ||
                              (!fl[FLAG_FIRST] && !fl[FLAG_ANY] && rule_sport[i] == sp);
                  if (rule_sip[i] == r.sip && rule_dip[i] == r.dip && rule_udp[i] == udp &&
                      same_port && rule_dport[i] == r.dport) dup = 1'b1;
               end
               if (dup) begin
                  o.status = STS_DUP;
               end else begin
                  for (int i = 0; i < NRULE && hit < 0; i++)
                     if (!rule_flags[i][FLAG_ENABLED]) hit = i;
                  if (hit < 0) begin
                     o.status = STS_FULL;
                  end else begin
                     rule_sip[hit] = r.sip;
                     rule_dip[hit] = r.dip;
                     rule_sport[hit] = sp;
                     rule_dport[hit] = r.dport;
                     rule_tag[hit] = r.tag;
                     rule_seen[hit] = r.now;
                     rule_udp[hit] = udp;
                     rule_flags[hit] = fl | 4'b0001;
                     o.slot = hit[7:0];
                  end
               end
            end
         end
         OP_REMOVE_TAG: begin
            for (int i = 0; i < NRULE; i++)
               if (rule_flags[i][FLAG_ENABLED] && rule_tag[i] == r.tag) begin
                  rule_flags[i][FLAG_ENABLED] = 1'b0;
                  if (cnt == 0) o.slot = i[7:0];
                  cnt++;
               end
            if (cnt == 0) o.status = STS_MISS;
         end
         OP_DISABLE: begin
            if (rule_flags[r.idx][FLAG_ENABLED]) begin
               rule_flags[r.idx][FLAG_ENABLED] = 1'b0;
               o.slot = r.idx;
               cnt = 1;
            end else begin
               o.status = STS_MISS;
            end
         end
         OP_AGE: begin
            lim = r.now - {22'd0, timeout_secs};
            for (int i = 0; i < NRULE; i++)
               if (rule_flags[i][FLAG_ENABLED] && !rule_flags[i][FLAG_PERMANENT] &&
                   $signed(lim) > $signed(rule_seen[i])) begin
                  rule_flags[i][FLAG_ENABLED] = 1'b0;
                  cnt++;
               end
         end
         OP_WATCH_ADD: begin
            if (find_watch(r.dip, r.dport) >= 0) begin
               o.status = STS_DUP;
            end else begin
               for (int i = 0; i < NWATCH && hit < 0; i++)
                  if (!watch_on[i]) hit = i;
               if (hit < 0) begin
                  o.status = STS_FULL;
               end else begin
                  watch_ip[hit] = r.dip;
                  watch_port[hit] = r.dport;
                  watch_on[hit] = 1'b1;
                  o.slot = hit[7:0];
               end
            end
         end
         OP_WATCH_DEL: begin
            hit = find_watch(r.dip, r.dport);
            if (hit < 0) begin
               o.status = STS_MISS;
            end else begin
               watch_on[hit] = 1'b0;
               o.slot = hit[7:0];
            end
         end
         default: begin
            for (int i = 0; i < NRULE; i++)
               if (rule_flags[i][FLAG_ENABLED] && rule_flags[i][FLAG_FIRST]) begin
                  rule_sport[i] = 16'd0;
                  cnt++;
               end
         end
      endcase
      o.affected = (cnt > 511) ? 9'd511 : cnt[8:0];
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_enabled || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // send one request; called at a rising edge, returns at its transfer edge
   task automatic send_filter_op(input filter_req_type r, output filter_rsp_type o);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      o = predict_filter_outcome(r);
      expected_outcomes.push_back(o);
   endtask

   task automatic issue(input filter_req_type r);
      filter_rsp_type o;
      send_filter_op(r, o);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic write_timeout(input logic [9:0] value);
      drain();
      csr_rule_timeout <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_secs = value;
   endtask

   function automatic filter_req_type make_req(logic [2:0] op, logic [1:0] proto, int s, int d,
                                               logic [15:0] sport, int dp, logic [1:0] mode,
                                               logic [31:0] tag);
      filter_req_type r;
      r = '0;
      r.op = op;
      r.now = clock_secs;
      r.proto = proto;
      r.sip = pool_ip[s];
      r.dip = pool_ip[d];
      r.sport = sport;
      r.dport = pool_port[dp];
      r.mode = mode;
      r.tag = tag;
      return r;
   endfunction

   task automatic test_directed();
      filter_req_type r;
      issue(make_req(OP_WATCH_ADD, 0, 0, 0, 0, 0, 0, 0));
      issue(make_req(OP_WATCH_ADD, 0, 0, 0, 0, 0, 0, 0));         // duplicate watch
      issue(make_req(OP_WATCH_ADD, 0, 0, 2, 0, 2, 0, 0));
      issue(make_req(OP_PACKET, 0, 1, 0, 16'd5, 0, 0, 0));        // other protocol
      issue(make_req(OP_PACKET, 3, 1, 0, 16'd5, 0, 0, 0));
      issue(make_req(OP_PACKET, PROTO_TCP, 1, 1, 16'd5, 1, 0, 0)); // not watched
      issue(make_req(OP_PACKET, PROTO_TCP, 1, 0, 16'd5, 0, 0, 0)); // no rule: drop
      issue(make_req(OP_ADD, 0, 1, 0, 16'd5, 0, MODE_EXACT, 1));   // bad protocol
      issue(make_req(OP_ADD, PROTO_TCP, 1, 0, 16'd5, 0, MODE_EXACT, 1));
      issue(make_req(OP_ADD, PROTO_TCP, 1, 0, 16'd5, 0, MODE_EXACT, 2)); // duplicate
      issue(make_req(OP_ADD, PROTO_UDP, 1, 0, 16'hFFFF, 0, MODE_FIRST, 2));
      issue(make_req(OP_ADD, PROTO_TCP, 2, 2, 16'd9, 2, MODE_ANY, 3));
      issue(make_req(OP_ADD, PROTO_UDP, 3, 2, 16'd9, 2, MODE_PERM, 32'hFFFFFFFF));
      issue(make_req(OP_PACKET, PROTO_TCP, 1, 0, 16'd5, 0, 0, 0));  // exact hit
      issue(make_req(OP_PACKET, PROTO_TCP, 2, 2, 16'd77, 2, 0, 0)); // any-port hit
      issue(make_req(OP_PACKET, PROTO_UDP, 1, 0, 16'd1234, 0, 0, 0)); // latch source port
      issue(make_req(OP_PACKET, PROTO_UDP, 1, 0, 16'd4321, 0, 0, 0)); // latched: drop
      issue(make_req(OP_RENEW, 0, 0, 0, 0, 0, 0, 0));
      issue(make_req(OP_PACKET, PROTO_UDP, 1, 0, 16'd4321, 0, 0, 0));
      issue(make_req(OP_DISABLE, 0, 0, 0, 0, 0, 0, 0));
      issue(make_req(OP_DISABLE, 0, 0, 0, 0, 0, 0, 0));              // already disabled
      r = make_req(OP_DISABLE, 0, 0, 0, 0, 0, 0, 0);
      r.idx = 8'hFF;
      issue(r);
      issue(make_req(OP_REMOVE_TAG, 0, 0, 0, 0, 0, 0, 32'd3));
      issue(make_req(OP_REMOVE_TAG, 0, 0, 0, 0, 0, 0, 32'd99));      // tag absent
      r = make_req(OP_AGE, 0, 0, 0, 0, 0, 0, 0);
      r.now = clock_secs + 32'd100000;                               // all but permanent
      issue(r);
      issue(make_req(OP_WATCH_DEL, 0, 0, 2, 0, 2, 0, 0));
      issue(make_req(OP_WATCH_DEL, 0, 0, 2, 0, 2, 0, 0));            // not present
   endtask

   task automatic test_watch_full();
      filter_req_type r;
      for (int i = 0; i < 17; i++) begin
         r = make_req(OP_WATCH_ADD, 0, 0, i % 4, 0, (i / 4) % 4, 0, 0);
         if (i == 16) begin
            r.dip = 32'h12345678;
            r.dport = 16'd7;
         end
         issue(r);
      end
   endtask

   task automatic test_rule_full();
      filter_req_type r;
      filter_rsp_type o;
      gaps_enabled = 1'b0;
      for (int i = 0; i < NRULE + 2; i++) begin
         r = make_req(OP_ADD, PROTO_TCP, 0, 1, 16'(1000 + i), 1, MODE_EXACT, 32'hA5A5A5A5);
         send_filter_op(r, o);
         if (o.status == STS_FULL) break;
      end
      gaps_enabled = 1'b1;
      issue(make_req(OP_PACKET, PROTO_TCP, 0, 1, 16'd1100, 1, 0, 0));
      issue(make_req(OP_REMOVE_TAG, 0, 0, 0, 0, 0, 0, 32'hA5A5A5A5));
   endtask

   task automatic test_age_edges();
      filter_req_type r;
      write_timeout(10'd10);
      clock_secs = 32'h7FFFFFF0;
      issue(make_req(OP_ADD, PROTO_UDP, 2, 3, 0, 3, MODE_EXACT, 4));
      r = make_req(OP_AGE, 0, 0, 0, 0, 0, 0, 0);
      r.now = 32'h7FFFFFF0 + 32'd10;                // equal limit: kept
      issue(r);
      r.now = 32'h7FFFFFF0 + 32'd11;                // one second past the limit: aged
      issue(r);
      clock_secs = 32'h00000005;
      issue(make_req(OP_ADD, PROTO_UDP, 2, 3, 0, 3, MODE_EXACT, 4));
      r.now = 32'd0;
      issue(r);
      r.now = 32'hFFFFFFFF;
      issue(r);
      r.now = 32'd16;
      issue(r);
      write_timeout(10'd600);
      clock_secs = 32'd50000;
   endtask

   task automatic test_random(input int count);
      filter_req_type r;
      int             sel;
      logic [191:0]   noise;
      for (int n = 0; n < count; n++) begin
         if (n % 300 == 150) begin
            // hold the sender until every result is back, then retune
            write_timeout(10'($urandom_range(10, 600)));
         end
         if (n % 200 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
         clock_secs += $urandom_range(0, 40);
         sel = $urandom_range(0, 99);
         r = make_req(OP_PACKET, 2'($urandom_range(1, 2)), $urandom_range(0, 3),
                      $urandom_range(0, 3), 16'(pool_port[$urandom_range(0, 3)]),
                      $urandom_range(0, 3), 2'($urandom_range(0, 3)),
                      pool_tag[$urandom_range(0, 3)]);
         if ($urandom_range(0, 3) == 0) r.sport = 16'($urandom);
         r.idx = 8'($urandom_range(0, 15));
         if (sel < 45) r.op = OP_PACKET;
         else if (sel < 65) r.op = OP_ADD;
         else if (sel < 70) r.op = OP_REMOVE_TAG;
         else if (sel < 76) r.op = OP_DISABLE;
         else if (sel < 81) r.op = OP_AGE;
         else if (sel < 87) r.op = OP_WATCH_ADD;
         else if (sel < 92) r.op = OP_WATCH_DEL;
         else if (sel < 96) r.op = OP_RENEW;
         else begin
            // noise: every field random
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(filter_req_type)-1:0];
            r.now = clock_secs + 32'($urandom_range(0, 2000)) - 32'd1000;
         end
         if ($urandom_range(0, 19) == 0) r.proto = 2'($urandom_range(0, 3));
         if (r.op == OP_AGE && $urandom_range(0, 9) == 0) r.now = $urandom;
         issue(r);
      end
   endtask

   // result check
   always @(posedge clock) begin
      filter_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_verdict !== e.verdict) begin
               $error("verdict expected %0d actual %0d", e.verdict, rsp_verdict);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_slot !== e.slot) begin
               $error("slot expected %0d actual %0d", e.slot, rsp_slot);
               fail_count++;
            end
            if (rsp_affected !== e.affected) begin
               $error("affected expected %0d actual %0d", e.affected, rsp_affected);
               fail_count++;
            end
         end
      end
   end

   // receiver backpressure: short bursts, rare long holds, free-running stretches
   int stall_left = 0;
   always @(posedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(0, 300);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NRULE; i++) rule_flags[i] = '0;
      for (int i = 0; i < NWATCH; i++) watch_on[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_age_edges();
      test_watch_full();
      test_rule_full();
      write_timeout(10'd30);
      test_random(850);
      drain();
      repeat (400) @(posedge clock);
      if (fail_count == 0 && expected_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/frtpf_pkg.sv
rtl/frtpf_ram.sv
rtl/frtpf_eval.sv
rtl/flow_rule_table_packet_filter.sv
sim/tb_flow_rule_table_packet_filter.sv
